// ----- rtl/hvmb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the hypervector majority bundling unit.
// Holds widths, register indexes and the control struct between top and merge; no dependencies.
package hvmb_pkg;

    localparam int unsigned DATA_W      = 64;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned TAIL_W      = 6;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam int unsigned MAX_VECTORS_DEF = 255;
    localparam int unsigned WORD_BITS_DEF   = 64;

    localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;

    localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_BITS    = CFG_INDEX_W'(1);

    localparam logic [CNT_W-1:0] VC_RESET   = CNT_W'(1);
    localparam logic [TAIL_W-1:0] TAIL_RESET = TAIL_W'(0);

    typedef struct packed {
        logic              load;
        logic              final_flag;
        logic [TAIL_W-1:0] tail_bits;
    } hvmb_merge_ctrl_t;

endpackage

// ----- rtl/hypervector_majority_bundle_unit.sv -----
`timescale 1ns / 1ps
// Top level of the hypervector majority bundling unit.
// Depends on hvmb_pkg, hvmb_lane and hvmb_merge.
//
// Bundles binary hypervectors by bitwise strict majority. Feed the words of one
// word position back to back, one word from each vector; the word that brings the
// count up to vector_count (0 reads as 1, values above MAX_VECTORS clamp to it)
// completes the group, and the next cycle its result word appears on the output
// with last copied from that word's final_word flag. A result bit is 1 where more
// than half of the words had it set; on a final word, bits at and above tail_bits
// are cleared (0 keeps all). The unit takes one word per clock cycle: one lane per
// bit updates its count as each word is taken, and the merge stage registers the
// result. The input stalls only when a word would complete a group while the
// previous result is still waiting in the output register and out_ready is low;
// words that do not complete a group are taken regardless. Write the registers
// (index 0 vector_count, index 1 tail_bits) only while the unit is idle; the
// configuration port is always ready.
module hypervector_majority_bundle_unit
#(
    parameter int unsigned MAX_VECTORS = hvmb_pkg::MAX_VECTORS_DEF,
    parameter int unsigned WORD_BITS   = hvmb_pkg::WORD_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input transactions
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [hvmb_pkg::DATA_W-1:0]          vector_word,
    input  logic                                 final_word,
    // result transactions
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [hvmb_pkg::DATA_W-1:0]          bundled_word,
    output logic                                 last,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hvmb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hvmb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Clamp ceiling for the vector count, limited by the counter width
    localparam int unsigned NCAP_INT = (MAX_VECTORS > hvmb_pkg::CNT_MAX)
                                       ? hvmb_pkg::CNT_MAX : MAX_VECTORS;
    localparam logic [hvmb_pkg::CNT_W-1:0] N_CAP = NCAP_INT[hvmb_pkg::CNT_W-1:0];

    logic [hvmb_pkg::CNT_W-1:0]  vector_count_reg;
    logic [hvmb_pkg::CNT_W-1:0]  vector_count_next;
    logic [hvmb_pkg::TAIL_W-1:0] tail_bits_reg;
    logic [hvmb_pkg::TAIL_W-1:0] tail_bits_next;
    logic [hvmb_pkg::CNT_W-1:0]  words_seen_reg;
    logic [hvmb_pkg::CNT_W-1:0]  words_seen_next;
    logic [hvmb_pkg::CNT_W-1:0]  words_inc;
    logic [hvmb_pkg::CNT_W-1:0]  n_eff;
    logic                        complete;
    logic                        in_accept;
    logic                        cfg_accept;
    logic [WORD_BITS-1:0]        votes;
    hvmb_pkg::hvmb_merge_ctrl_t  merge_ctrl;

    // Effective vector count: zero reads as one, large values clamp
    always_comb
    begin
        priority if (vector_count_reg == '0)
        begin
            n_eff = hvmb_pkg::CNT_W'(1);
        end
        else if (vector_count_reg > N_CAP)
        begin
            n_eff = N_CAP;
        end
        else
        begin
            n_eff = vector_count_reg;
        end
    end

    assign words_inc = words_seen_reg + hvmb_pkg::CNT_W'(1);
    assign complete  = words_inc >= n_eff;

    // Hold the input only when this word would overwrite a waiting result
    assign in_ready  = !(complete && out_valid && !out_ready);
    assign in_accept = in_valid && in_ready;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    always_comb
    begin
        words_seen_next = words_seen_reg;
        if (in_accept)
        begin
            words_seen_next = complete ? '0 : words_inc;
        end
    end

    // Configuration registers; writes to other indexes are dropped
    always_comb
    begin
        vector_count_next = vector_count_reg;
        tail_bits_next    = tail_bits_reg;
        if (cfg_accept)
        begin
            unique case (cfg_index)
                hvmb_pkg::REG_VECTOR_COUNT: vector_count_next = cfg_data;
                hvmb_pkg::REG_TAIL_BITS:    tail_bits_next    = cfg_data[hvmb_pkg::TAIL_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_count_reg <= hvmb_pkg::VC_RESET;
            tail_bits_reg    <= hvmb_pkg::TAIL_RESET;
            words_seen_reg   <= '0;
        end
        else
        begin
            vector_count_reg <= vector_count_next;
            tail_bits_reg    <= tail_bits_next;
            words_seen_reg   <= words_seen_next;
        end
    end

    // One counting lane per live bit of the word
    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_lane
        hvmb_lane u_lane
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .accept   (in_accept),
            .complete (complete),
            .bit_in   (vector_word[i]),
            .n_eff    (n_eff),
            .vote     (votes[i])
        );
    end

    assign merge_ctrl.load       = in_accept && complete;
    assign merge_ctrl.final_flag = final_word;
    assign merge_ctrl.tail_bits  = tail_bits_reg;

    hvmb_merge
    #(
        .WORD_BITS (WORD_BITS)
    )
    u_merge
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .votes        (votes),
        .ctrl         (merge_ctrl),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .bundled_word (bundled_word),
        .last         (last)
    );

    // A completing transaction always leaves a result behind
    a_complete_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && complete |=> out_valid)
        else $error("completing word did not produce a result");

    // A completing transaction restarts the word count
    a_complete_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && complete |=> words_seen_reg == '0)
        else $error("word count not cleared after completion");

    // The input is only held back by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    // The word count never wraps
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        words_seen_reg != hvmb_pkg::CNT_W'(hvmb_pkg::CNT_MAX))
        else $error("word count reached its top value");

endmodule

// ----- rtl/hvmb_lane.sv -----
`timescale 1ns / 1ps
// One bit lane: saturating vote counter and strict-majority decision.
// Depends on hvmb_pkg for the counter width.
module hvmb_lane
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      complete,
    input  logic                      bit_in,
    input  logic [hvmb_pkg::CNT_W-1:0] n_eff,
    output logic                      vote
);

    logic [hvmb_pkg::CNT_W-1:0] cnt_reg;
    logic [hvmb_pkg::CNT_W-1:0] cnt_next;
    logic [hvmb_pkg::CNT_W-1:0] cnt_inc;

    // Saturate at the counter's top value
    assign cnt_inc = (bit_in && (cnt_reg != hvmb_pkg::CNT_W'(hvmb_pkg::CNT_MAX)))
                     ? cnt_reg + hvmb_pkg::CNT_W'(1) : cnt_reg;

    // Strict majority: twice the count above the vector count
    assign vote = {cnt_inc, 1'b0} > {1'b0, n_eff};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = complete ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/hvmb_merge.sv -----
`timescale 1ns / 1ps
// Merge stage: gathers the lane votes, applies the tail mask, holds the result register.
// Depends on hvmb_pkg for widths and the control struct.
module hvmb_merge
#(
    parameter int unsigned WORD_BITS = hvmb_pkg::WORD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [WORD_BITS-1:0]           votes,
    input  hvmb_pkg::hvmb_merge_ctrl_t     ctrl,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [hvmb_pkg::DATA_W-1:0]    bundled_word,
    output logic                           last
);

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [hvmb_pkg::DATA_W-1:0] word_reg;
    logic                        last_reg;
    logic [hvmb_pkg::DATA_W-1:0] masked;
    logic                        apply_mask;

    assign apply_mask = ctrl.final_flag && (ctrl.tail_bits != '0)
                        && ({1'b0, ctrl.tail_bits} < 7'(WORD_BITS));

    for (genvar i = 0; i < hvmb_pkg::DATA_W; i++)
    begin : g_bit
        if (i < WORD_BITS)
        begin : g_live
            assign masked[i] = votes[i]
                               && (!apply_mask || (7'(i) < {1'b0, ctrl.tail_bits}));
        end
        else
        begin : g_dead
            assign masked[i] = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            word_reg <= masked;
            last_reg <= ctrl.final_flag;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bundled_word = word_reg;
    assign last         = last_reg;

endmodule
